// ===== sv/bir_pkg.sv =====
// ----------------------------------------------------------------------------
// bir_pkg
// Shared constants, types and the per-axis neighbor function of the
// bilinear image resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bir_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int FRAC_BITS      = 16;

  localparam int XB          = $clog2(MAX_SRC_WIDTH);
  localparam int YB          = $clog2(MAX_SRC_HEIGHT);
  localparam int ADDR_W      = XB + YB;
  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

  localparam int SW_W    = 9;                  // src size register width
  localparam int DW_W    = 13;                 // dst size register width
  localparam int COORD_W = 12;
  localparam int STEP_W  = SW_W + FRAC_BITS;   // numerator and quotient width
  localparam int POS_W   = STEP_W + COORD_W;
  localparam int PIX_W   = POS_W - FRAC_BITS;
  localparam int WT_W    = FRAC_BITS + 1;
  localparam int W2_W    = 2 * WT_W;
  localparam int CNT_W   = $clog2(STEP_W + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DW_W;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [WT_W-1:0] W_ONE  = WT_W'(1) << FRAC_BITS;
  localparam logic [WT_W-1:0] W_HALF = WT_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [XB-1:0]   idx_lo;
    logic [XB-1:0]   idx_hi;
    logic [WT_W-1:0] w_lo;
    logic [WT_W-1:0] w_hi;
    logic            v_lo;
    logic            v_hi;
  } axis_t;

  // Resolve one axis: neighbor indices, weights and in-source flags.
  function automatic axis_t axis_f(input logic [POS_W-1:0] pos,
                                   input logic [SW_W-1:0] size);
    axis_t             a;
    logic [PIX_W-1:0]  pix;
    logic [PIX_W-1:0]  pm1;
    logic [PIX_W:0]    pp1;
    logic [WT_W-1:0]   frac;
    logic              up;
    pix  = pos[POS_W-1:FRAC_BITS];
    pm1  = pix - PIX_W'(1);
    pp1  = {1'b0, pix} + (PIX_W + 1)'(1);
    frac = {1'b0, pos[FRAC_BITS-1:0]};
    up   = frac > W_HALF;
    if (up) begin
      a.idx_lo = pix[XB-1:0];
      a.idx_hi = pp1[XB-1:0];
      a.w_hi   = frac - W_HALF;
      a.w_lo   = W_ONE - (frac - W_HALF);
      a.v_lo   = pix < PIX_W'(size);
      a.v_hi   = pp1 < (PIX_W + 1)'(size);
    end else begin
      a.idx_lo = pm1[XB-1:0];
      a.idx_hi = pix[XB-1:0];
      a.w_lo   = W_HALF - frac;
      a.w_hi   = W_ONE - (W_HALF - frac);
      a.v_lo   = (pix != '0) && (pix <= PIX_W'(size));
      a.v_hi   = pix < PIX_W'(size);
    end
    return a;
  endfunction

endpackage

// ===== sv/bilinear_image_resampler_core.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_resampler_core
// RGB source store with bilinear resampling of destination pixels.
// ----------------------------------------------------------------------------
// Load transactions (opcode 0) write one 24-bit pixel into a 256x256 source
// store, one per cycle while input is not stalled; loads outside the store
// are dropped and give no result. Query transactions (opcode 1) give one
// result each: the bilinear sample of the source at the center of destination
// pixel (col, row), with neighbors outside the source contributing zero and
// channels wrapping at 8 bits. A query reads its four neighbors in turn
// through the single store port, and the store reader takes the next query
// only as the last neighbor of the one before is read. A load waits until
// all queries ahead of it have read the store. After reset and after every
// configuration write the step divider runs, and input is stalled while it
// runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_image_resampler_core
  import bir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [COORD_W-1:0]    in_col,
  input  logic [COORD_W-1:0]    in_row,
  input  logic [7:0]            in_red_in,
  input  logic [7:0]            in_green_in,
  input  logic [7:0]            in_blue_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_red_out,
  output logic [7:0]            out_green_out,
  output logic [7:0]            out_blue_out,
  output logic                  out_coord_ok
);

  // Configuration registers
  logic [SW_W-1:0] src_w_r, src_h_r;
  logic [DW_W-1:0] dst_w_r, dst_h_r;
  logic [SW_W-1:0] sw, sh;
  logic [DW_W-1:0] dw, dh;

  // Step divider (two restoring dividers, one bit per cycle)
  logic              div_go_r, div_run_r;
  logic [CNT_W-1:0]  div_cnt_r;
  logic [STEP_W-1:0] qx_r, qy_r;
  logic [DW_W-1:0]   rx_r, ry_r;
  logic [DW_W:0]     tx, ty;
  logic              div_busy;

  // Query pipeline
  logic               p1_v_r, p1_ok_r;
  logic [POS_W-1:0]   p1_px_r, p1_py_r;
  logic               p2_v_r, p2_ok_r;
  axis_t              p2_ax_r, p2_ay_r;
  axis_t              ax, ay;
  logic               act_r, s3_ok_r;
  logic [1:0]         k_r;
  axis_t              s3_ax_r, s3_ay_r;
  logic               rd_v_r, rd_first_r, rd_last_r, rd_nb_r, rd_ok_r;
  logic [W2_W-1:0]    rd_w_r;
  logic [7:0]         acc_r [3];
  logic [7:0]         acc_nxt [3];
  logic [W2_W+7:0]    term [3];
  logic [1:0]         pend_r;
  logic               s3_load, p1_move, p1_free, q_busy;
  logic               q_acc, ld_acc, ld_in;

  // Source store
  logic [23:0]        mem [STORE_DEPTH];
  logic [23:0]        rdata_r;
  logic [ADDR_W-1:0]  mem_addr, iss_addr;
  logic               mem_we;

  // Result queue
  logic [24:0]        fq_r [2];
  logic               fq_wp_r, fq_rp_r;
  logic [1:0]         fq_cnt_r;
  logic               push, pop;

  // --------------------------------------------------------------------------
  // Configuration and effective sizes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SW_W'(MAX_SRC_WIDTH);
      src_h_r <= SW_W'(MAX_SRC_HEIGHT);
      dst_w_r <= DW_W'(256);
      dst_h_r <= DW_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_w_r <= cfg_wdata[SW_W-1:0];
        REG_SRC_HEIGHT: src_h_r <= cfg_wdata[SW_W-1:0];
        REG_DST_WIDTH:  dst_w_r <= cfg_wdata;
        REG_DST_HEIGHT: dst_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate source sizes into 1 to the store size; a zero destination acts as one.
  assign sw = (src_w_r == '0) ? SW_W'(1) :
              (src_w_r > SW_W'(MAX_SRC_WIDTH)) ? SW_W'(MAX_SRC_WIDTH) : src_w_r;
  assign sh = (src_h_r == '0) ? SW_W'(1) :
              (src_h_r > SW_W'(MAX_SRC_HEIGHT)) ? SW_W'(MAX_SRC_HEIGHT) : src_h_r;
  assign dw = (dst_w_r == '0) ? DW_W'(1) : dst_w_r;
  assign dh = (dst_h_r == '0) ? DW_W'(1) : dst_h_r;

  // --------------------------------------------------------------------------
  // Step = (src << FRAC_BITS) / dst, recomputed after reset and every write
  // --------------------------------------------------------------------------
  assign tx = {rx_r, qx_r[STEP_W-1]};
  assign ty = {ry_r, qy_r[STEP_W-1]};
  assign div_busy = div_go_r | div_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_go_r  <= 1'b1;
      div_run_r <= 1'b0;
      div_cnt_r <= '0;
    end else if (cfg_we) begin
      div_go_r  <= 1'b1;
      div_run_r <= 1'b0;
    end else if (div_go_r) begin
      div_go_r  <= 1'b0;
      div_run_r <= 1'b1;
      div_cnt_r <= CNT_W'(STEP_W);
      qx_r      <= {sw, FRAC_BITS'(0)};
      qy_r      <= {sh, FRAC_BITS'(0)};
      rx_r      <= '0;
      ry_r      <= '0;
    end else if (div_run_r) begin
      if (tx >= {1'b0, dw}) begin
        rx_r <= DW_W'(tx - {1'b0, dw});
        qx_r <= {qx_r[STEP_W-2:0], 1'b1};
      end else begin
        rx_r <= tx[DW_W-1:0];
        qx_r <= {qx_r[STEP_W-2:0], 1'b0};
      end
      if (ty >= {1'b0, dh}) begin
        ry_r <= DW_W'(ty - {1'b0, dh});
        qy_r <= {qy_r[STEP_W-2:0], 1'b1};
      end else begin
        ry_r <= ty[DW_W-1:0];
        qy_r <= {qy_r[STEP_W-2:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r - CNT_W'(1);
      if (div_cnt_r == CNT_W'(1)) begin
        div_run_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input handshake
  // --------------------------------------------------------------------------
  // Hand the next query to the store reader when it frees up and the result
  // queue has room for everything already in flight.
  assign s3_load = p2_v_r && (!act_r || (k_r == 2'd3)) &&
                   ((3'(fq_cnt_r) + 3'(pend_r)) < 3'd2);
  assign p1_move = p1_v_r && (!p2_v_r || s3_load);
  assign p1_free = !p1_v_r || p1_move;
  assign q_busy  = p1_v_r | p2_v_r | act_r;

  // A load must not overtake a query that has yet to read the store.
  assign in_stall = div_busy || ((in_opcode == OP_QUERY) ? !p1_free : q_busy);
  assign q_acc    = in_valid && !in_stall && (in_opcode == OP_QUERY);
  assign ld_acc   = in_valid && !in_stall && (in_opcode == OP_LOAD);
  assign ld_in    = (in_col < COORD_W'(MAX_SRC_WIDTH)) &&
                    (in_row < COORD_W'(MAX_SRC_HEIGHT));

  // --------------------------------------------------------------------------
  // Stage 1: step times coordinate; stage 2: neighbors and weights
  // --------------------------------------------------------------------------
  assign ax = axis_f(p1_px_r + POS_W'(qx_r >> 1), sw);
  assign ay = axis_f(p1_py_r + POS_W'(qy_r >> 1), sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      if (q_acc) begin
        p1_v_r <= 1'b1;
      end else if (p1_move) begin
        p1_v_r <= 1'b0;
      end
      if (p1_move) begin
        p2_v_r <= 1'b1;
      end else if (s3_load) begin
        p2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_acc) begin
      p1_px_r <= POS_W'(qx_r) * POS_W'(in_col);
      p1_py_r <= POS_W'(qy_r) * POS_W'(in_row);
      p1_ok_r <= (DW_W'(in_col) < dst_w_r) && (DW_W'(in_row) < dst_h_r);
    end
    if (p1_move) begin
      p2_ax_r <= ax;
      p2_ay_r <= ay;
      p2_ok_r <= p1_ok_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: read the four neighbors, one per cycle
  // --------------------------------------------------------------------------
  assign iss_addr = {(k_r[1] ? s3_ay_r.idx_hi : s3_ay_r.idx_lo),
                     (k_r[0] ? s3_ax_r.idx_hi : s3_ax_r.idx_lo)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      k_r    <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (s3_load) begin
        act_r <= 1'b1;
        k_r   <= '0;
      end else if (act_r) begin
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3) begin
          act_r <= 1'b0;
        end
      end
      rd_v_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_ax_r <= p2_ax_r;
      s3_ay_r <= p2_ay_r;
      s3_ok_r <= p2_ok_r;
    end
    rd_first_r <= (k_r == 2'd0);
    rd_last_r  <= (k_r == 2'd3);
    rd_ok_r    <= s3_ok_r;
    rd_nb_r    <= s3_ok_r &&
                  (k_r[0] ? s3_ax_r.v_hi : s3_ax_r.v_lo) &&
                  (k_r[1] ? s3_ay_r.v_hi : s3_ay_r.v_lo);
    rd_w_r     <= W2_W'(k_r[0] ? s3_ax_r.w_hi : s3_ax_r.w_lo) *
                  W2_W'(k_r[1] ? s3_ay_r.w_hi : s3_ay_r.w_lo);
  end

  // Single-port store: a load writes only while no query reads.
  assign mem_we   = ld_acc && ld_in;
  assign mem_addr = mem_we ? {in_row[YB-1:0], in_col[XB-1:0]} : iss_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {in_red_in, in_green_in, in_blue_in};
    end
    rdata_r <= mem[mem_addr];
  end

  // --------------------------------------------------------------------------
  // Accumulate weight times channel, truncated, modulo 256
  // --------------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      term[c]    = (W2_W + 8)'(rd_w_r) * (W2_W + 8)'(rdata_r[16 - 8 * c +: 8]);
      acc_nxt[c] = (rd_first_r ? 8'd0 : acc_r[c]) +
                   (rd_nb_r ? term[c][2 * FRAC_BITS +: 8] : 8'd0);
    end
  end

  assign push = rd_v_r && rd_last_r;

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= acc_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, s3_load} - {1'b0, push};
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry result queue toward the output
  // --------------------------------------------------------------------------
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fq_wp_r  <= 1'b0;
      fq_rp_r  <= 1'b0;
      fq_cnt_r <= '0;
    end else begin
      if (push) begin
        fq_wp_r <= ~fq_wp_r;
      end
      if (pop) begin
        fq_rp_r <= ~fq_rp_r;
      end
      fq_cnt_r <= fq_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fq_r[fq_wp_r] <= {acc_nxt[0], acc_nxt[1], acc_nxt[2], rd_ok_r};
    end
  end

  assign out_valid     = fq_cnt_r != '0;
  assign out_red_out   = fq_r[fq_rp_r][24:17];
  assign out_green_out = fq_r[fq_rp_r][16:9];
  assign out_blue_out  = fq_r[fq_rp_r][8:1];
  assign out_coord_ok  = fq_r[fq_rp_r][0];

endmodule

// ===== sv/bir_checker.sv =====
// ----------------------------------------------------------------------------
// bir_checker
// Port-level assertions for the bilinear image resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bir_checker
  import bir_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  in_opcode,
  input logic [COORD_W-1:0]    in_col,
  input logic [COORD_W-1:0]    in_row,
  input logic [7:0]            in_red_in,
  input logic [7:0]            in_green_in,
  input logic [7:0]            in_blue_in,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [7:0]            out_red_out,
  input logic [7:0]            out_green_out,
  input logic [7:0]            out_blue_out,
  input logic                  out_coord_ok
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out) &&
    $stable(out_green_out) && $stable(out_blue_out) && $stable(out_coord_ok))
    else $error("stalled result changed");

  // A query outside the destination returns black.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_coord_ok |->
    out_red_out == 8'd0 && out_green_out == 8'd0 && out_blue_out == 8'd0)
    else $error("nonzero channel on outside query");

  // Reset drops pending results.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // A configuration write recomputes the step; input waits for it.
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input taken while step is recomputed");

endmodule

bind bilinear_image_resampler_core bir_checker u_bir_checker (.*);

// ===== verif/tb_bilinear_image_resampler_core.sv =====
// ----------------------------------------------------------------------------
// tb_bilinear_image_resampler_core
// Self-checking regression for the bilinear RGB resampler core.
// ----------------------------------------------------------------------------
// A local predictor keeps its own copy of the source store and of the size
// registers and works out every query result at the moment the query is
// accepted. Results are compared field by field, in order, against the
// predicted pixels. Stimulus covers directed corner cases, size extremes
// with register saturation, and random traffic under three idle profiles,
// including one long output hold that backs the core up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bilinear_image_resampler_core;
  import bir_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       ok;
  } pixel_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_opcode;
  logic [COORD_W-1:0]    in_col;
  logic [COORD_W-1:0]    in_row;
  logic [7:0]            in_red_in;
  logic [7:0]            in_green_in;
  logic [7:0]            in_blue_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_red_out;
  logic [7:0]            out_green_out;
  logic [7:0]            out_blue_out;
  logic                  out_coord_ok;

  // Predictor state: source store, written map and size registers.
  logic [23:0]        pix_store [STORE_DEPTH];
  bit                 pix_written [STORE_DEPTH];
  logic [SW_W-1:0]    src_w_reg;
  logic [SW_W-1:0]    src_h_reg;
  logic [DW_W-1:0]    dst_w_reg;
  logic [DW_W-1:0]    dst_h_reg;

  pixel_result_t      pending_pixels [$];

  int  tx_idle_pct;
  int  rx_idle_pct;
  int  rx_hold_cycles;
  int  mismatches;
  bit  failed;
  int  loads_sent;
  int  queries_sent;
  int  results_seen;
  int  idle_count;

  bilinear_image_resampler_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_col        (in_col),
    .in_row        (in_row),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_coord_ok  (out_coord_ok)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate a size register into [1, hi].
  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // One axis of the sample: two neighbor indices and their weights.
  function automatic void resolve_axis(input int unsigned src, input int unsigned dst,
                                       input longint unsigned coord,
                                       output longint lo, output longint hi,
                                       output longint unsigned wlo,
                                       output longint unsigned whi);
    longint unsigned one;
    longint unsigned half;
    longint unsigned step;
    longint unsigned pos;
    longint unsigned frac;
    longint          pix;
    one  = 64'd1 << FRAC_BITS;
    half = 64'd1 << (FRAC_BITS - 1);
    step = (longint'(src) << FRAC_BITS) / dst;
    pos  = (step >> 1) + step * coord;
    pix  = longint'(pos >> FRAC_BITS);
    frac = pos & (one - 1);
    if (frac > half) begin
      lo  = pix;
      hi  = pix + 1;
      whi = frac - half;
      wlo = one - whi;
    end else begin
      lo  = pix - 1;
      hi  = pix;
      wlo = half - frac;
      whi = one - wlo;
    end
  endfunction

  // Bilinear sample of destination pixel (col, row) from the local store.
  function automatic pixel_result_t resample_pixel(input int unsigned col,
                                                   input int unsigned row);
    pixel_result_t   res;
    int unsigned     sw;
    int unsigned     sh;
    longint          xs [2];
    longint          ys [2];
    longint unsigned wx [2];
    longint unsigned wy [2];
    longint unsigned w;
    logic [23:0]     p;
    logic [7:0]      acc [3];
    res = '0;
    if (col >= dst_w_reg || row >= dst_h_reg) return res;
    sw = clamp_size(src_w_reg, MAX_SRC_WIDTH);
    sh = clamp_size(src_h_reg, MAX_SRC_HEIGHT);
    resolve_axis(sw, clamp_size(dst_w_reg, 13'h1FFF), col, xs[0], xs[1], wx[0], wx[1]);
    resolve_axis(sh, clamp_size(dst_h_reg, 13'h1FFF), row, ys[0], ys[1], wy[0], wy[1]);
    acc = '{8'd0, 8'd0, 8'd0};
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 2; i++) begin
        // drop neighbors outside the source
        if (xs[i] >= 0 && ys[j] >= 0 && xs[i] < sw && ys[j] < sh) begin
          p = pix_store[ys[j] * MAX_SRC_WIDTH + xs[i]];
          w = wx[i] * wy[j];
          for (int c = 0; c < 3; c++)
            acc[c] += 8'((w * longint'(p[16 - 8 * c +: 8])) >> (2 * FRAC_BITS));
        end
      end
    end
    res.red   = acc[0];
    res.green = acc[1];
    res.blue  = acc[2];
    res.ok    = 1'b1;
    return res;
  endfunction

  // Offer one transaction and hold it until the core takes it.
  task automatic send_item(input logic op, input int unsigned col, input int unsigned row,
                           input logic [23:0] rgb);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_col      <= COORD_W'(col);
    in_row      <= COORD_W'(row);
    in_red_in   <= rgb[23:16];
    in_green_in <= rgb[15:8];
    in_blue_in  <= rgb[7:0];
    do @(posedge clk); while (in_stall);
    // accepted at this edge: update the predictor
    if (op == OP_LOAD) begin
      loads_sent++;
      if (col < MAX_SRC_WIDTH && row < MAX_SRC_HEIGHT) begin
        pix_store[row * MAX_SRC_WIDTH + col]   = rgb;
        pix_written[row * MAX_SRC_WIDTH + col] = 1'b1;
      end
    end else begin
      queries_sent++;
      pending_pixels.push_back(resample_pixel(col, row));
    end
  endtask

  task automatic load_pixel(input int unsigned col, input int unsigned row);
    send_item(OP_LOAD, col, row, 24'($urandom));
  endtask

  task automatic query_pixel(input int unsigned col, input int unsigned row);
    send_item(OP_QUERY, col, row, 24'($urandom));
  endtask

  // Wait until every predicted pixel has come back and the core is quiet.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      REG_SRC_WIDTH:  src_w_reg = SW_W'(value);
      REG_SRC_HEIGHT: src_h_reg = SW_W'(value);
      REG_DST_WIDTH:  dst_w_reg = DW_W'(value);
      REG_DST_HEIGHT: dst_h_reg = DW_W'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reprogram all sizes while idle, then load every unwritten source pixel.
  task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                           input int unsigned dw, input int unsigned dh);
    int unsigned ew;
    int unsigned eh;
    wait_idle();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    if ($urandom_range(3) == 0) write_reg(CFG_IDX_W'($urandom_range(4, 7)), $urandom);
    ew = clamp_size(src_w_reg, MAX_SRC_WIDTH);
    eh = clamp_size(src_h_reg, MAX_SRC_HEIGHT);
    for (int y = 0; y < eh; y++)
      for (int x = 0; x < ew; x++)
        if (!pix_written[y * MAX_SRC_WIDTH + x]) load_pixel(x, y);
  endtask

  // Reset sizes: the store is empty, so only queries outside the destination and loads outside the store.
  task automatic test_reset_sizes();
    query_pixel(256, 0);
    query_pixel(0, 256);
    query_pixel(4095, 4095);
    load_pixel(300, 5);
    load_pixel(5, 4095);
  endtask

  task automatic test_directed_corners();
    set_sizes(4, 3, 7, 5);
    send_item(OP_LOAD, 0, 0, 24'hFFFFFF);
    send_item(OP_LOAD, 3, 2, 24'h000000);
    send_item(OP_LOAD, 1, 1, 24'hFF00FF);
    query_pixel(0, 0);
    query_pixel(6, 4);
    query_pixel(3, 2);
    query_pixel(7, 0);
    query_pixel(0, 5);
    query_pixel(4095, 0);
    // upsample and downsample with exact half fractions
    set_sizes(4, 3, 2, 3);
    query_pixel(0, 0);
    query_pixel(1, 2);
    set_sizes(4, 3, 8, 6);
    query_pixel(7, 5);
    query_pixel(2, 3);
  endtask

  // Width and height extremes, register saturation and zero sizes.
  task automatic test_size_extremes();
    set_sizes(256, 1, 4096, 1);
    query_pixel(0, 0);
    query_pixel(4095, 0);
    query_pixel(2048, 0);
    set_sizes(1, 256, 1, 4096);
    query_pixel(0, 4095);
    query_pixel(0, 1);
    set_sizes(511, 0, 8191, 3);
    query_pixel(4095, 2);
    query_pixel(100, 0);
    set_sizes(0, 300, 0, 0);
    query_pixel(0, 0);
    set_sizes(2, 2, 1, 1);
    query_pixel(0, 0);
  endtask

  // Random sizes kept small, mostly in-range queries with some loads.
  // A nonzero hold stalls the output right after the first resize.
  task automatic random_phase(input int n_items, input int hold_cycles);
    int sent;
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    sent = 0;
    while (sent < n_items) begin
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 12);
      if ($urandom_range(7) == 0) sh = $urandom_range(0, 16);
      if ($urandom_range(5) == 0) begin
        // wide source kept to its first row, which is already loaded
        sw = $urandom_range(0, 511);
        sh = 1;
      end
      dw = ($urandom_range(4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 24);
      dh = ($urandom_range(4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 24);
      set_sizes(sw, sh, dw, dh);
      if (hold_cycles > 0) begin
        rx_hold_cycles = hold_cycles;
        hold_cycles    = 0;
      end
      repeat (40) begin
        case ($urandom_range(9))
          0: load_pixel($urandom_range(4095), $urandom_range(4095));
          1: load_pixel($urandom_range(clamp_size(src_w_reg, MAX_SRC_WIDTH) - 1),
                        $urandom_range(clamp_size(src_h_reg, MAX_SRC_HEIGHT) - 1));
          2: query_pixel($urandom_range(4095), $urandom_range(4095));
          default: query_pixel($urandom_range(dst_w_reg == 0 ? 0 : dst_w_reg - 1) % 4096,
                               $urandom_range(dst_h_reg == 0 ? 0 : dst_h_reg - 1) % 4096);
        endcase
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    tx_idle_pct = 20;
    rx_idle_pct = 45;
    random_phase(80, 0);
    tx_idle_pct = 45;
    rx_idle_pct = 20;
    random_phase(80, 0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // hold the output long enough for the core to back up into its input
    random_phase(80, 400);
  endtask

  // Output side: random stall, long hold on request, in-order compare.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall <= 1'b1;
        rx_hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    pixel_result_t exp_pix;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: %0h %0h %0h ok=%0b", out_red_out, out_green_out,
                   out_blue_out, out_coord_ok);
      end else begin
        exp_pix = pending_pixels.pop_front();
        if (out_red_out !== exp_pix.red || out_green_out !== exp_pix.green ||
            out_blue_out !== exp_pix.blue || out_coord_ok !== exp_pix.ok) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected %0h %0h %0h ok=%0b, got %0h %0h %0h ok=%0b",
                     exp_pix.red, exp_pix.green, exp_pix.blue, exp_pix.ok,
                     out_red_out, out_green_out, out_blue_out, out_coord_ok);
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("bilinear_image_resampler_core regression: fail");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_opcode      = OP_LOAD;
    in_col         = '0;
    in_row         = '0;
    in_red_in      = '0;
    in_green_in    = '0;
    in_blue_in     = '0;
    tx_idle_pct    = 20;
    rx_idle_pct    = 45;
    rx_hold_cycles = 0;
    mismatches     = 0;
    failed         = 1'b0;
    loads_sent     = 0;
    queries_sent   = 0;
    results_seen   = 0;
    idle_count     = 0;
    src_w_reg      = SW_W'(256);
    src_h_reg      = SW_W'(256);
    dst_w_reg      = DW_W'(256);
    dst_h_reg      = DW_W'(256);
    foreach (pix_written[i]) pix_written[i] = 1'b0;
    foreach (pix_store[i]) pix_store[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_sizes();
    test_directed_corners();
    test_size_extremes();
    test_random_traffic();

    wait_idle();
    if (pending_pixels.size() != 0) failed = 1'b1;
    $display("covered %0d loads and %0d queries, %0d results checked, %0d mismatches",
             loads_sent, queries_sent, results_seen, mismatches);
    if (!failed) begin
      $display("bilinear_image_resampler_core regression: pass");
    end else begin
      $display("bilinear_image_resampler_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bir_pkg.sv
sv/bilinear_image_resampler_core.sv
sv/bir_checker.sv
verif/tb_bilinear_image_resampler_core.sv
